@@ design/dll_pkg.sv @@
package dll_pkg;

   localparam int DefPoolNodes = 16;
   localparam int DefWordBits  = 32;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NONE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [3:0] CMD_FIRST     = 4'd0;
   localparam logic [3:0] CMD_NEXT      = 4'd1;
   localparam logic [3:0] CMD_LAST      = 4'd2;
   localparam logic [3:0] CMD_PREV      = 4'd3;
   localparam logic [3:0] CMD_PUSH_HEAD = 4'd4;
   localparam logic [3:0] CMD_PUSH_TAIL = 4'd5;
   localparam logic [3:0] CMD_PUSH_CUR  = 4'd6;
   localparam logic [3:0] CMD_POP_HEAD  = 4'd7;
   localparam logic [3:0] CMD_POP_TAIL  = 4'd8;
   localparam logic [3:0] CMD_POP_CUR   = 4'd9;
   localparam logic [3:0] CMD_CLEAN     = 4'd10;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_LINK,
      S_FIX,
      S_DONE
   } seq_state_type;

   // link memory write request
   typedef struct packed {
      logic        we;
   } link_wr_type;

endpackage

@@ design/doubly_linked_list_cursor_engine_core.sv @@
// Doubly linked list with cursor over a pool of POOL_NODES nodes. Raise start
// with req_cmd and req_data_in while busy is low; exactly one result word
// follows, shown on rsp_data_out and rsp_status for a single cycle with
// rsp_valid high, and it cannot be held off, so capture it then. Busy stays
// high from acceptance through the result strobe and falls after it: the
// node memories have one write port each and a registered read, so a
// command walks read, link, fix-up and reply steps in a small sequencer.
// Reset clears the used map and all pointers at once; no clearing pass is
// needed.
module doubly_linked_list_cursor_engine_core #(
   parameter int POOL_NODES = dll_pkg::DefPoolNodes,
   parameter int WORD_BITS  = dll_pkg::DefWordBits
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [3:0]           req_cmd,
   input  logic [WORD_BITS-1:0] req_data_in,
   output logic                 rsp_valid,
   output logic [WORD_BITS-1:0] rsp_data_out,
   output logic [1:0]           rsp_status
);
   import dll_pkg::*;

   localparam int PtrBits = $clog2(POOL_NODES + 1);
   localparam int IdxBits = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam logic [PtrBits-1:0] NIL = PtrBits'(POOL_NODES);

   seq_state_type state_ff, state_in;

   logic [3:0]           cmd_ff;
   logic [WORD_BITS-1:0] din_ff;
   logic [POOL_NODES-1:0] used_ff, used_in;
   logic [PtrBits-1:0] head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic [PtrBits-1:0] tgt_ff, tgt_in;     // node being visited/removed/new
   logic [1:0]           st_ff, st_in;
   logic [WORD_BITS-1:0] dout_ff;
   logic                 go_ff, go_in;     // command has work past the read step
   logic [PtrBits-1:0]   aft_rd_hold;      // neighbor for the second push write

   // data word store
   logic [WORD_BITS-1:0] word_mem [POOL_NODES];
   logic [WORD_BITS-1:0] word_rd;
   logic                 word_we;
   logic [IdxBits-1:0]   word_addr;

   // link stores
   logic [PtrBits-1:0] aft_rd, bef_rd;
   logic [PtrBits-1:0] aft_wd, bef_wd;
   logic [IdxBits-1:0] aft_wa, bef_wa, link_ra;
   link_wr_type        aft_wr, bef_wr;

   // lowest free node
   logic [PtrBits-1:0] free_idx;
   always_comb begin
      free_idx = NIL;
      for (int i = POOL_NODES - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = PtrBits'(i);
         end
      end
   end

   function automatic logic live(input logic [PtrBits-1:0] p);
      live = (p != NIL);
   endfunction

   function automatic logic [IdxBits-1:0] ix(input logic [PtrBits-1:0] p);
      ix = p[IdxBits-1:0];
   endfunction

   assign busy = (state_ff != S_IDLE);
   logic accept;
   assign accept = start && !busy;

   dll_link_ram #(.PoolNodes(POOL_NODES), .PtrBits(PtrBits), .IdxBits(IdxBits)) u_after (
      .clock(clock), .we(aft_wr.we), .waddr(aft_wa), .wdata(aft_wd),
      .raddr(link_ra), .rdata(aft_rd)
   );
   dll_link_ram #(.PoolNodes(POOL_NODES), .PtrBits(PtrBits), .IdxBits(IdxBits)) u_before (
      .clock(clock), .we(bef_wr.we), .waddr(bef_wa), .wdata(bef_wd),
      .raddr(link_ra), .rdata(bef_rd)
   );

   // word store: written on push, read at the node being visited
   always_ff @(posedge clock) begin
      if (word_we) begin
         word_mem[word_addr] <= din_ff;
      end
      word_rd <= word_mem[word_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_READ;
         S_READ: state_in = S_LINK;
         S_LINK: state_in = S_FIX;
         S_FIX:  state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control per step
   always_comb begin
      used_in = used_ff; head_in = head_ff; tail_in = tail_ff; cur_in = cur_ff;
      tgt_in = tgt_ff; st_in = st_ff; go_in = go_ff;
      word_we = 1'b0; word_addr = ix(tgt_ff);
      aft_wr = '0; bef_wr = '0; aft_wa = ix(tgt_ff); bef_wa = ix(tgt_ff);
      aft_wd = NIL; bef_wd = NIL; link_ra = ix(tgt_ff);
      case (state_ff)
         S_IDLE: begin
            st_in = ST_NONE; go_in = 1'b0;
         end
         // pick the target node and start reading its links (the cursor's for push-at-cursor); clean empties the list
         S_READ: begin
            case (cmd_ff)
               CMD_FIRST, CMD_POP_HEAD: begin tgt_in = head_ff; go_in = live(head_ff); end
               CMD_LAST,  CMD_POP_TAIL: begin tgt_in = tail_ff; go_in = live(tail_ff); end
               CMD_NEXT, CMD_PREV, CMD_POP_CUR: begin
                  tgt_in = cur_ff; go_in = live(cur_ff);
               end
               CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
                  tgt_in = free_idx; go_in = live(free_idx);
                  if (!live(free_idx)) st_in = ST_FULL;
               end
               CMD_PUSH_CUR: begin
                  tgt_in = free_idx; go_in = live(cur_ff) && live(free_idx);
                  if (live(cur_ff) && !live(free_idx)) st_in = ST_FULL;
               end
               CMD_CLEAN: begin
                  used_in = '0; head_in = NIL; tail_in = NIL; cur_in = NIL;
                  st_in = ST_OK;
               end
               default: ;
            endcase
            link_ra = ix(tgt_in);
            if (cmd_ff == CMD_PUSH_CUR) link_ra = ix(cur_ff);
            word_addr = ix(tgt_in);
         end
         // links of the target (or cursor) are in aft_rd/bef_rd
         S_LINK: begin
            if (go_ff) begin
               case (cmd_ff)
                  CMD_FIRST, CMD_LAST: begin cur_in = tgt_ff; st_in = ST_OK; go_in = 1'b0; end
                  CMD_NEXT, CMD_PREV: begin
                     tgt_in = (cmd_ff == CMD_NEXT) ? aft_rd : bef_rd;
                     go_in = live(tgt_in);
                     link_ra = ix(tgt_in); word_addr = ix(tgt_in);
                  end
                  CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
                     word_we = 1'b1; used_in[ix(tgt_ff)] = 1'b1; st_in = ST_OK;
                     aft_wr.we = 1'b1; bef_wr.we = 1'b1;
                     if (!live(head_ff)) begin
                        head_in = tgt_ff; tail_in = tgt_ff;
                     end else if (cmd_ff == CMD_PUSH_HEAD) begin
                        aft_wd = head_ff; head_in = tgt_ff;
                     end else begin
                        bef_wd = tail_ff; tail_in = tgt_ff;
                     end
                  end
                  CMD_PUSH_CUR: begin
                     word_we = 1'b1; used_in[ix(tgt_ff)] = 1'b1; st_in = ST_OK;
                     aft_wr.we = 1'b1; bef_wr.we = 1'b1;
                     aft_wd = aft_rd; bef_wd = cur_ff;
                     if (!live(aft_rd)) tail_in = tgt_ff;
                  end
                  CMD_POP_HEAD, CMD_POP_TAIL, CMD_POP_CUR: begin
                     used_in[ix(tgt_ff)] = 1'b0; st_in = ST_OK;
                     if (live(bef_rd)) begin
                        aft_wr.we = 1'b1; aft_wa = ix(bef_rd); aft_wd = aft_rd;
                     end else head_in = aft_rd;
                     if (live(aft_rd)) begin
                        bef_wr.we = 1'b1; bef_wa = ix(aft_rd); bef_wd = bef_rd;
                     end else tail_in = bef_rd;
                     if (cmd_ff == CMD_POP_CUR) cur_in = aft_rd;
                     else if (cur_ff == tgt_ff) cur_in = NIL;
                  end
                  default: ;
               endcase
            end
         end
         // second link write for push; finish moves
         S_FIX: begin
            if (go_ff) begin
               case (cmd_ff)
                  CMD_NEXT, CMD_PREV: begin cur_in = tgt_ff; st_in = ST_OK; end
                  CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
                     if (cmd_ff == CMD_PUSH_HEAD && live(aft_rd_hold)) begin
                        bef_wr.we = 1'b1; bef_wa = ix(aft_rd_hold); bef_wd = tgt_ff;
                     end
                     if (cmd_ff == CMD_PUSH_TAIL && live(aft_rd_hold)) begin
                        aft_wr.we = 1'b1; aft_wa = ix(aft_rd_hold); aft_wd = tgt_ff;
                     end
                  end
                  CMD_PUSH_CUR: begin
                     aft_wr.we = 1'b1; aft_wa = ix(cur_ff); aft_wd = tgt_ff;
                     if (live(aft_rd_hold)) begin
                        bef_wr.we = 1'b1; bef_wa = ix(aft_rd_hold); bef_wd = tgt_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   // neighbor captured at the link step for the second push write
   always_ff @(posedge clock) begin
      if (state_ff == S_LINK) begin
         case (cmd_ff)
            CMD_PUSH_HEAD: aft_rd_hold <= live(head_ff) ? head_ff : NIL;
            CMD_PUSH_TAIL: aft_rd_hold <= live(head_ff) ? tail_ff : NIL;
            default:       aft_rd_hold <= aft_rd;
         endcase
      end
   end

   // data word captured when the visited or removed node's word is read
   always_ff @(posedge clock) begin
      if (state_ff == S_LINK && cmd_ff != CMD_NEXT && cmd_ff != CMD_PREV) begin
         dout_ff <= word_rd;
      end else if (state_ff == S_FIX) begin
         if (cmd_ff == CMD_NEXT || cmd_ff == CMD_PREV) dout_ff <= word_rd;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         head_ff  <= NIL;
         tail_ff  <= NIL;
         cur_ff   <= NIL;
         go_ff    <= 1'b0;
         st_ff    <= ST_NONE;
         tgt_ff   <= NIL;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         cur_ff   <= cur_in;
         go_ff    <= go_in;
         st_ff    <= st_in;
         tgt_ff   <= tgt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         din_ff <= req_data_in;
      end
   end

   // reply
   logic reads_word;
   assign reads_word = (cmd_ff == CMD_FIRST) || (cmd_ff == CMD_NEXT) ||
                       (cmd_ff == CMD_LAST) || (cmd_ff == CMD_PREV) ||
                       (cmd_ff == CMD_POP_HEAD) || (cmd_ff == CMD_POP_TAIL) ||
                       (cmd_ff == CMD_POP_CUR);
   always_comb begin
      rsp_valid    = (state_ff == S_DONE);
      rsp_status   = st_ff;
      rsp_data_out = (st_ff == ST_OK && reads_word) ? dout_ff : '0;
   end

   // the result strobe follows each acceptance after the read, link and fix-up steps
   a_rsp_timing: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("result strobe not four cycles after accept");

   // never busy-free while a result is pending
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while idle");

   // head and tail are null together
   a_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((head_ff == NIL) == (tail_ff == NIL)))
      else $error("head/tail disagree on empty");

   // status never reserved code
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3))
      else $error("bad status code");

endmodule

@@ design/dll_link_ram.sv @@
// Link store: one write port, one registered read port, for one link direction.
module dll_link_ram #(
   parameter int PoolNodes = dll_pkg::DefPoolNodes,
   parameter int PtrBits   = $clog2(PoolNodes + 1),
   parameter int IdxBits   = (PoolNodes > 1) ? $clog2(PoolNodes) : 1
) (
   input  logic               clock,
   input  logic               we,
   input  logic [IdxBits-1:0] waddr,
   input  logic [PtrBits-1:0] wdata,
   input  logic [IdxBits-1:0] raddr,
   output logic [PtrBits-1:0] rdata
);
   import dll_pkg::*;

   logic [PtrBits-1:0] mem [PoolNodes];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
